// ----- sv/sbph_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_pkg
// Shared types and constants of the spectrum bar meter with peak hold.
// ----------------------------------------------------------------------------
package sbph_pkg;

  localparam int unsigned COLUMNS_DEF = 480;

  localparam int COL_W   = 9;
  localparam int MAG_W   = 20;
  localparam int GAIN_W  = 8;
  localparam int ROW_W   = 10;
  localparam int STEP_W  = 6;
  localparam int CLS_W   = 2;
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = MAG_W + GAIN_W;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 10;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 40;

  localparam logic [IDX_W-1:0] REG_GAIN        = 3'd0;
  localparam logic [IDX_W-1:0] REG_FULL_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_HIGH_LEVEL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MID_LEVEL   = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOW_LEVEL   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FALL_STEP   = 3'd5;

  localparam logic [GAIN_W-1:0] GAIN_RST        = 8'd10;
  localparam logic [ROW_W-1:0]  FULL_HEIGHT_RST = 10'd800;
  localparam logic [ROW_W-1:0]  HIGH_LEVEL_RST  = 10'd600;
  localparam logic [ROW_W-1:0]  MID_LEVEL_RST   = 10'd400;
  localparam logic [ROW_W-1:0]  LOW_LEVEL_RST   = 10'd200;
  localparam logic [STEP_W-1:0] FALL_STEP_RST   = 6'd2;

  localparam logic [CLS_W-1:0] CLS_RED    = 2'd0;
  localparam logic [CLS_W-1:0] CLS_YELLOW = 2'd1;
  localparam logic [CLS_W-1:0] CLS_GREEN  = 2'd2;
  localparam logic [CLS_W-1:0] CLS_CYAN   = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic [ROW_W-1:0]  full_height;
    logic [ROW_W-1:0]  high_level;
    logic [ROW_W-1:0]  mid_level;
    logic [ROW_W-1:0]  low_level;
    logic [STEP_W-1:0] fall_step;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] peak;
    logic [ROW_W-1:0] next;
    logic             erase_valid;
    logic             draw_valid;
  } peak_res_t;

endpackage

// ----- sv/sbph_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module sbph_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sbph_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sbph_pkg::CFG_W-1:0]    cfg_data,
  output sbph_pkg::cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain        <= sbph_pkg::GAIN_RST;
      cfg.full_height <= sbph_pkg::FULL_HEIGHT_RST;
      cfg.high_level  <= sbph_pkg::HIGH_LEVEL_RST;
      cfg.mid_level   <= sbph_pkg::MID_LEVEL_RST;
      cfg.low_level   <= sbph_pkg::LOW_LEVEL_RST;
      cfg.fall_step   <= sbph_pkg::FALL_STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sbph_pkg::REG_GAIN:        cfg.gain        <= cfg_data[sbph_pkg::GAIN_W-1:0];
        sbph_pkg::REG_FULL_HEIGHT: cfg.full_height <= cfg_data[sbph_pkg::ROW_W-1:0];
        sbph_pkg::REG_HIGH_LEVEL:  cfg.high_level  <= cfg_data[sbph_pkg::ROW_W-1:0];
        sbph_pkg::REG_MID_LEVEL:   cfg.mid_level   <= cfg_data[sbph_pkg::ROW_W-1:0];
        sbph_pkg::REG_LOW_LEVEL:   cfg.low_level   <= cfg_data[sbph_pkg::ROW_W-1:0];
        sbph_pkg::REG_FALL_STEP:   cfg.fall_step   <= cfg_data[sbph_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/sbph_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_scale
// Gain scaling, saturation to bar height, bar top row and color class.
// ----------------------------------------------------------------------------
module sbph_scale (
  input  logic [sbph_pkg::MAG_W-1:0] magnitude,
  input  sbph_pkg::cfg_t             cfg,
  output logic [sbph_pkg::ROW_W-1:0] bar_top,
  output logic [sbph_pkg::CLS_W-1:0] color_class
);

  logic [sbph_pkg::PROD_W-1:0]                  product;
  logic [sbph_pkg::PROD_W-sbph_pkg::FRAC_W-1:0] height_raw;
  logic [sbph_pkg::ROW_W-1:0]                   height;

  assign product    = sbph_pkg::PROD_W'(magnitude) * sbph_pkg::PROD_W'(cfg.gain);
  assign height_raw = product[sbph_pkg::PROD_W-1:sbph_pkg::FRAC_W];

  always_comb begin
    if (height_raw > (sbph_pkg::PROD_W-sbph_pkg::FRAC_W)'(cfg.full_height)) begin
      height = cfg.full_height;
    end else begin
      height = height_raw[sbph_pkg::ROW_W-1:0];
    end
  end

  assign bar_top = cfg.full_height - height;

  always_comb begin
    priority if (height > cfg.high_level) begin
      color_class = sbph_pkg::CLS_RED;
    end else if (height > cfg.mid_level) begin
      color_class = sbph_pkg::CLS_YELLOW;
    end else if (height > cfg.low_level) begin
      color_class = sbph_pkg::CLS_GREEN;
    end else begin
      color_class = sbph_pkg::CLS_CYAN;
    end
  end

endmodule

// ----- sv/sbph_peak_upd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_peak_upd
// Peak capture against the bar top, falling step and floor clamp.
// ----------------------------------------------------------------------------
module sbph_peak_upd (
  input  logic [sbph_pkg::ROW_W-1:0]  old_peak,
  input  logic [sbph_pkg::ROW_W-1:0]  bar_top,
  input  logic [sbph_pkg::ROW_W-1:0]  full_height,
  input  logic [sbph_pkg::STEP_W-1:0] fall_step,
  output sbph_pkg::peak_res_t         res
);

  logic [sbph_pkg::ROW_W-1:0] peak;
  logic [sbph_pkg::ROW_W:0]   fallen;

  assign peak = (old_peak >= bar_top) ? bar_top : old_peak;

  always_comb begin
    if (peak < full_height) begin
      fallen = {1'b0, peak} + (sbph_pkg::ROW_W+1)'(fall_step);
    end else begin
      fallen = {1'b0, peak};
    end
  end

  assign res.peak        = peak;
  assign res.next        = (fallen >= {1'b0, full_height}) ? full_height
                                                           : fallen[sbph_pkg::ROW_W-1:0];
  assign res.erase_valid = (old_peak < full_height);
  assign res.draw_valid  = (peak < full_height);

endmodule

// ----- sv/sbph_peak_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbph_peak_mem
// Held peak store per column with registered read and a clearing sweep.
// ----------------------------------------------------------------------------
module sbph_peak_mem #(
  parameter int unsigned COLUMNS = sbph_pkg::COLUMNS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(COLUMNS)-1:0] rd_addr,
  output logic [sbph_pkg::ROW_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(COLUMNS)-1:0] wr_addr,
  input  logic [sbph_pkg::ROW_W-1:0] wr_data,
  output logic                       busy
);

  localparam int ADDR_W = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(COLUMNS - 1);

  logic [sbph_pkg::ROW_W-1:0] mem [COLUMNS];
  logic [ADDR_W-1:0]          clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      if (clr_addr == LAST) begin
        busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= sbph_pkg::FULL_HEIGHT_RST;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/spectrum_bar_peak_hold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold
// Bar meter with a falling held peak per display column.
// ----------------------------------------------------------------------------
// Pipeline: the input word passes the registered stages p, q and r to the output.
// Throughput: one word per cycle while m_tready allows, set by the read-modify-write
//   of the peak store (one read and one write port), with forwarding between updates.
// Reset: configuration registers return to defaults; a clearing sweep fills the
//   peak store with the reset floor, s_tready stays low meanwhile.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_hold #(
  parameter int unsigned COLUMNS = sbph_pkg::COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // column [8:0], magnitude [28:9], zero [31:29]
  input  logic [sbph_pkg::IN_W-1:0]     s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // bar_top [9:0], color_class [11:10], erase_valid [12], old_peak_row [22:13],
  // draw_valid [23], new_peak_row [33:24], zero [39:34]
  output logic [sbph_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_write,
  input  logic [sbph_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sbph_pkg::CFG_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(COLUMNS);

  sbph_pkg::cfg_t cfg;

  logic                          busy;
  logic                          adv;
  logic                          accept;
  logic [sbph_pkg::COL_W-1:0]    in_column;
  logic [sbph_pkg::MAG_W-1:0]    in_magnitude;
  logic                          in_range;

  logic                          p_valid;
  logic [sbph_pkg::COL_W-1:0]    p_column;
  logic [sbph_pkg::MAG_W-1:0]    p_magnitude;
  logic                          p_in_range;
  logic                          p_fwd_hit;
  logic [sbph_pkg::ROW_W-1:0]    p_fwd_val;
  logic [sbph_pkg::ROW_W-1:0]    rd_data;
  logic [sbph_pkg::ROW_W-1:0]    p_bar_top;
  logic [sbph_pkg::CLS_W-1:0]    p_color_class;
  logic [sbph_pkg::ROW_W-1:0]    p_old_next;

  logic                          q_valid;
  logic [sbph_pkg::COL_W-1:0]    q_column;
  logic                          q_in_range;
  logic [sbph_pkg::ROW_W-1:0]    q_old;
  logic [sbph_pkg::ROW_W-1:0]    q_bar_top;
  logic [sbph_pkg::CLS_W-1:0]    q_color_class;
  sbph_pkg::peak_res_t           q_res;

  logic                          wr_en;

  logic                          r_valid;
  logic [sbph_pkg::ROW_W-1:0]    r_bar_top;
  logic [sbph_pkg::CLS_W-1:0]    r_color_class;
  logic                          r_erase_valid;
  logic [sbph_pkg::ROW_W-1:0]    r_old_peak_row;
  logic                          r_draw_valid;
  logic [sbph_pkg::ROW_W-1:0]    r_new_peak_row;

  assign in_column    = s_tdata[sbph_pkg::COL_W-1:0];
  assign in_magnitude = s_tdata[sbph_pkg::COL_W+sbph_pkg::MAG_W-1:sbph_pkg::COL_W];
  assign in_range     = (32'(in_column) < COLUMNS);

  assign adv      = !r_valid || m_tready;
  assign s_tready = adv && !busy;
  assign accept   = s_tvalid && s_tready;
  assign wr_en    = adv && q_valid && q_in_range;

  sbph_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbph_peak_mem #(
    .COLUMNS (COLUMNS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (ADDR_W'(in_column)),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (ADDR_W'(q_column)),
    .wr_data (q_res.next),
    .busy    (busy)
  );

  sbph_scale u_scale (
    .magnitude   (p_magnitude),
    .cfg         (cfg),
    .bar_top     (p_bar_top),
    .color_class (p_color_class)
  );

  sbph_peak_upd u_upd (
    .old_peak    (q_old),
    .bar_top     (q_bar_top),
    .full_height (cfg.full_height),
    .fall_step   (cfg.fall_step),
    .res         (q_res)
  );

  // floor if out of range; else newest of: write this edge, write at read time, memory
  always_comb begin
    priority if (!p_in_range) begin
      p_old_next = cfg.full_height;
    end else if (wr_en && (q_column == p_column)) begin
      p_old_next = q_res.next;
    end else if (p_fwd_hit) begin
      p_old_next = p_fwd_val;
    end else begin
      p_old_next = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      q_valid <= 1'b0;
      r_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= accept;
      q_valid <= p_valid;
      r_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_column       <= in_column;
      p_magnitude    <= in_magnitude;
      p_in_range     <= in_range;
      p_fwd_hit      <= wr_en && (q_column == in_column);
      p_fwd_val      <= q_res.next;

      q_column       <= p_column;
      q_in_range     <= p_in_range;
      q_old          <= p_old_next;
      q_bar_top      <= p_bar_top;
      q_color_class  <= p_color_class;

      r_bar_top      <= q_bar_top;
      r_color_class  <= q_color_class;
      r_erase_valid  <= q_res.erase_valid;
      r_old_peak_row <= q_old;
      r_draw_valid   <= q_res.draw_valid;
      r_new_peak_row <= q_res.peak;
    end
  end

  assign m_tvalid = r_valid;
  assign m_tdata  = {6'd0, r_new_peak_row, r_draw_valid, r_old_peak_row, r_erase_valid,
                     r_color_class, r_bar_top};

endmodule
